>>> hw/rtl/suft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// suft_pkg
// shared command codes, register indexes and entry type for the sorted uid flag table
// ----------------------------------------------------------------------------
package suft_pkg;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_LOOKUP = 3'd2;
  localparam logic [2:0] CMD_READ   = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic REG_DELETED_MASK = 1'b0;
  localparam logic REG_SEEN_MASK    = 1'b1;

  localparam int UID_W  = 32;
  localparam int FLAG_W = 16;

  // one table entry as held in memory
  typedef struct packed {
    logic [UID_W-1:0]  uid;
    logic [FLAG_W-1:0] flags;
  } entry_t;

endpackage
`default_nettype wire

>>> hw/rtl/sorted_uid_flag_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_uid_flag_table
// sorted identifier table with flag words, stored in one entry memory
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one command transaction (insert/update, remove, lookup,
//   read, clear); out_* returns exactly one result transaction per command.
//   cfg_* writes deleted_mask (index 0) or seen_mask (index 1) while idle;
//   a pending register write is taken first and holds in_ready low.
//   Commands run one at a time around a single entry memory with a
//   registered read port. Lookup and insert run a binary search of at most
//   ceil(log2(CAPACITY+1)) probes, each a read then a compare, then decide;
//   insert shifts the tail up and remove pulls it down, one read and one
//   write per entry moved; every command ends with a backward scan for the
//   highest live uid, which stops at the first live entry. The worst case is
//   an insert at the front with every entry deleted. in_ready rises again
//   when the block is back in idle after the result is taken, unless a
//   register write is pending.
//   A stalled receiver holds the block in its done state, result unchanged.
//   Reset (rst_n low, synchronous) empties the table and restores the mask
//   defaults; memory is not cleared, entries past the count never reach a result.
// ----------------------------------------------------------------------------
module sorted_uid_flag_table #(
  parameter int CAPACITY = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_command,
  input  wire logic [31:0] in_uid,
  input  wire logic [15:0] in_flags,
  input  wire logic [10:0] in_position,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_found,
  output logic [31:0]      out_uid_out,
  output logic [15:0]      out_flags_out,
  output logic [10:0]      out_entry_count,
  output logic [10:0]      out_deleted_count,
  output logic [31:0]      out_highest_live_uid,
  output logic             out_last_unseen,
  output logic             out_table_full,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR,
    S_RM_RD, S_RM_CHK, S_PULL_RD, S_PULL_WR, S_SCAN_INIT, S_SCAN_RD,
    S_SCAN_CMP, S_DONE
  } state_t;

  state_t state_r;
  logic [2:0]  cmd_r;
  logic [31:0] uid_r;
  logic [15:0] flg_r;
  logic [CW-1:0] lo_r, hi_r, idx_r, count_r, del_r;
  logic [15:0] dmask_r, smask_r;
  logic found_r, full_r, unseen_r;
  logic [31:0] uid_o_r, high_r;
  logic [15:0] flg_o_r;

  logic we;
  logic [AW-1:0] waddr, raddr;
  suft_pkg::entry_t wdata, rdata;

  suft_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic [CW-1:0] mid;
  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  logic hit;
  assign hit = (lo_r < count_r) && (rdata.uid == uid_r);

  // position checks at acceptance
  logic [31:0] pos_ext, cnt_ext;
  logic read_miss;
  assign pos_ext = {21'd0, in_position};
  assign cnt_ext = 32'(count_r);
  assign read_miss = (in_command == suft_pkg::CMD_READ) && !(pos_ext < cnt_ext);

  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_found = found_r;
  assign out_uid_out = uid_o_r;
  assign out_flags_out = flg_o_r;
  assign out_entry_count = 11'(count_r);
  assign out_deleted_count = 11'(del_r);
  assign out_highest_live_uid = high_r;
  assign out_last_unseen = unseen_r;
  assign out_table_full = full_r;

  // memory port drive
  always_comb begin
    we = 1'b0;
    waddr = AW'(idx_r);
    wdata.uid = rdata.uid;
    wdata.flags = rdata.flags;
    raddr = AW'(idx_r);
    case (state_r)
      S_SRCH_RD: begin
        if (lo_r < hi_r) raddr = AW'(mid);
        else raddr = AW'(lo_r);
      end
      S_DECIDE: begin
        if (cmd_r == suft_pkg::CMD_INSERT && hit) begin
          we = 1'b1;
          waddr = AW'(lo_r);
          wdata.uid = uid_r;
          wdata.flags = flg_r;
        end
      end
      S_SHIFT_RD: begin
        if (idx_r == lo_r) begin
          we = 1'b1;
          waddr = AW'(lo_r);
          wdata.uid = uid_r;
          wdata.flags = flg_r;
        end else begin
          raddr = AW'(idx_r - ONE_C);
        end
      end
      S_SHIFT_WR: we = 1'b1;
      S_PULL_RD: raddr = AW'(idx_r + ONE_C);
      S_PULL_WR: we = 1'b1;
      S_SCAN_RD: raddr = AW'(idx_r - ONE_C);
      default: ;
    endcase
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      del_r <= '0;
      dmask_r <= 16'd8;
      smask_r <= 16'd1;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == suft_pkg::REG_DELETED_MASK) dmask_r <= cfg_data;
            else smask_r <= cfg_data;
          end else if (in_valid) begin
            cmd_r <= in_command; uid_r <= in_uid; flg_r <= in_flags;
            found_r <= 1'b0; full_r <= 1'b0; flg_o_r <= '0;
            uid_o_r <= {32{read_miss}};
            high_r <= '0; unseen_r <= 1'b0;
            lo_r <= '0; hi_r <= count_r;
            case (in_command)
              suft_pkg::CMD_INSERT, suft_pkg::CMD_LOOKUP: state_r <= S_SRCH_RD;
              suft_pkg::CMD_REMOVE: begin
                if (in_position != 11'd0 && pos_ext <= cnt_ext) begin
                  idx_r <= CW'(in_position - 11'd1);
                  state_r <= S_RM_RD;
                end else begin
                  state_r <= S_SCAN_INIT;
                end
              end
              suft_pkg::CMD_READ: begin
                if (!read_miss) begin
                  idx_r <= CW'(in_position);
                  state_r <= S_RM_RD;
                end else begin
                  state_r <= S_SCAN_INIT;
                end
              end
              suft_pkg::CMD_CLEAR: begin
                count_r <= '0; del_r <= '0; state_r <= S_SCAN_INIT;
              end
              default: state_r <= S_SCAN_INIT;
            endcase
          end
        end
        // binary search: issue read at mid, then compare
        S_SRCH_RD: begin
          idx_r <= mid;
          if (lo_r < hi_r) state_r <= S_SRCH_CMP;
          else state_r <= S_DECIDE;  // read of lo issued
        end
        S_SRCH_CMP: begin
          if (rdata.uid < uid_r) lo_r <= idx_r + ONE_C;
          else hi_r <= idx_r;
          state_r <= S_SRCH_RD;
        end
        S_DECIDE: begin
          if (cmd_r == suft_pkg::CMD_LOOKUP) begin
            if (hit) begin found_r <= 1'b1; flg_o_r <= rdata.flags; end
            state_r <= S_SCAN_INIT;
          end else if (hit) begin
            found_r <= 1'b1;
            if (|(rdata.flags & dmask_r) && !(|(flg_r & dmask_r))) begin
              if (del_r != '0) del_r <= del_r - ONE_C;
            end else if (!(|(rdata.flags & dmask_r)) && |(flg_r & dmask_r)) begin
              if (del_r < CAP_C) del_r <= del_r + ONE_C;
            end
            state_r <= S_SCAN_INIT;
          end else if (count_r >= CAP_C) begin
            full_r <= 1'b1; state_r <= S_SCAN_INIT;
          end else begin
            idx_r <= count_r; state_r <= S_SHIFT_RD;
          end
        end
        // move entries up one place, top down; new entry written at lo
        S_SHIFT_RD: begin
          if (idx_r == lo_r) begin
            count_r <= count_r + ONE_C;
            if (|(flg_r & dmask_r) && del_r < CAP_C) del_r <= del_r + ONE_C;
            state_r <= S_SCAN_INIT;
          end else begin
            state_r <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          idx_r <= idx_r - ONE_C; state_r <= S_SHIFT_RD;
        end
        S_RM_RD: state_r <= S_RM_CHK;
        S_RM_CHK: begin
          if (cmd_r == suft_pkg::CMD_READ) begin
            uid_o_r <= rdata.uid; flg_o_r <= rdata.flags;
            state_r <= S_SCAN_INIT;
          end else begin
            if (|(rdata.flags & dmask_r) && del_r != '0) del_r <= del_r - ONE_C;
            count_r <= count_r - ONE_C;
            state_r <= S_PULL_RD;
          end
        end
        // move entries down one place, bottom up
        S_PULL_RD: begin
          if (idx_r < count_r) state_r <= S_PULL_WR;
          else state_r <= S_SCAN_INIT;
        end
        S_PULL_WR: begin
          idx_r <= idx_r + ONE_C; state_r <= S_PULL_RD;
        end
        // backward scan for highest live uid and last entry state
        S_SCAN_INIT: begin
          idx_r <= count_r; state_r <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          if (idx_r == '0) state_r <= S_DONE;
          else state_r <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (idx_r == count_r) begin
            unseen_r <= !(rdata.uid != '0 && |(rdata.flags & (smask_r | dmask_r)));
          end
          if (rdata.uid != '0 && !(|(rdata.flags & dmask_r))) begin
            high_r <= rdata.uid; state_r <= S_DONE;
          end else begin
            idx_r <= idx_r - ONE_C; state_r <= S_SCAN_RD;
          end
        end
        S_DONE: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a result never reports more deleted entries than held capacity
  assert property (@(posedge clk) disable iff (!rst_n) del_r <= CAP_C)
    else $error("deleted count above capacity");
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CAP_C)
    else $error("entry count above capacity");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_entry_count))
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready && cfg_valid && cfg_ready))
    else $error("register write taken with a command");

endmodule
`default_nettype wire

>>> hw/rtl/suft_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// suft_mem
// entry memory, one write and one registered read port
// ----------------------------------------------------------------------------
module suft_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire suft_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output suft_pkg::entry_t     rdata
);

  suft_pkg::entry_t mem [DEPTH];

  // synchronous write and read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
